// File: src/ptmq_pkg.sv
package ptmq_pkg;

  // Sizing
  localparam int NUM_TASKS  = 8;
  localparam int POOL_SLOTS = 8;
  localparam int MSG_WIDTH  = 32;

  localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int TASK_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // Fixed field widths at the ports
  localparam int REQ_W     = 2;
  localparam int TID_W     = 3;
  localparam int MSG_IN_W  = 32;
  localparam int STATUS_W  = 2;
  localparam int MSG_OUT_W = 32;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_SEND   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PICKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // run the request and write the result register
  } ptmq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_full;  // result register holds an untaken result
  } ptmq_sts_t;

endpackage

// File: src/ptmq_ctrl.sv
module ptmq_ctrl
  import ptmq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  logic      res_ready_i,
  input  ptmq_sts_t sts_i,
  output ptmq_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  // Handshake and command decode
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        // result register free, or its transfer completes now
        if (!sts_i.out_full || res_ready_i) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/ptmq_datapath.sv
module ptmq_datapath
  import ptmq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptmq_cmd_t            cmd_i,
  output ptmq_sts_t            sts_o,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [TID_W-1:0]     task_id_i,
  input  logic [MSG_IN_W-1:0]  msg_in_i,
  input  logic                 res_ready_i,
  output logic                 res_valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [MSG_OUT_W-1:0] msg_out_o,
  output logic                 pending_o
);

  // Captured request
  logic [REQ_W-1:0]     req_q;
  logic [TID_W-1:0]     tid_q;
  logic [MSG_WIDTH-1:0] msg_q;

  // Pool and per-task list state
  logic [POOL_SLOTS-1:0] used_q, used_d;
  logic [NUM_TASKS-1:0]  nonempty_q, nonempty_d;
  logic [MSG_WIDTH-1:0]  slot_msg_q [POOL_SLOTS];
  logic [SLOT_W-1:0]     slot_link_q [POOL_SLOTS];
  logic [SLOT_W-1:0]     head_q [NUM_TASKS];
  logic [SLOT_W-1:0]     tail_q [NUM_TASKS];

  // Result register
  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  out_status_q, status_d;
  logic [MSG_WIDTH-1:0] out_msg_q, mout_d;
  logic                 out_pend_q, pend_d;

  // Write strobes for the pointer and payload arrays
  logic              wr_msg, wr_link, wr_head, wr_tail;
  logic [SLOT_W-1:0] wr_link_idx, wr_head_val;

  logic              task_ok;
  logic [TASK_W-1:0] t;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] h;

  assign task_ok = (32'(tid_q) < NUM_TASKS);
  assign t       = TASK_W'(tid_q);
  assign h       = head_q[t];

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = POOL_SLOTS - 1; s >= 0; s--) begin
      if (!used_q[s]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(s);
      end
    end
  end

  // Request execution
  always_comb begin
    used_d      = used_q;
    nonempty_d  = nonempty_q;
    status_d    = ST_OK;
    mout_d      = '0;
    pend_d      = 1'b0;
    wr_msg      = 1'b0;
    wr_link     = 1'b0;
    wr_head     = 1'b0;
    wr_tail     = 1'b0;
    wr_link_idx = tail_q[t];
    wr_head_val = free_idx;
    case (req_q)
      REQ_SEND: begin
        if (!task_ok || !free_found) begin
          status_d = ST_FULL;
          pend_d   = task_ok && nonempty_q[t];
        end else begin
          used_d[free_idx] = 1'b1;
          wr_msg  = 1'b1;
          wr_tail = 1'b1;
          if (nonempty_q[t]) begin
            wr_link = 1'b1;
          end else begin
            wr_head       = 1'b1;
            nonempty_d[t] = 1'b1;
          end
          pend_d = 1'b1;
        end
      end
      REQ_PICKUP: begin
        if (!task_ok || !nonempty_q[t]) begin
          status_d = ST_EMPTY;
        end else begin
          mout_d    = slot_msg_q[h];
          used_d[h] = 1'b0;
          if (h == tail_q[t]) begin
            nonempty_d[t] = 1'b0;
          end else begin
            wr_head     = 1'b1;
            wr_head_val = slot_link_q[h];
            pend_d      = 1'b1;
          end
        end
      end
      default: begin
        // query and the unused code only report
        pend_d = task_ok && nonempty_q[t];
      end
    endcase
  end

  assign out_valid_d = cmd_i.exec ? 1'b1 : (res_ready_i ? 1'b0 : out_valid_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.exec) begin
        used_q     <= used_d;
        nonempty_q <= nonempty_d;
      end
    end
  end

  // Payload, pointers and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      tid_q <= task_id_i;
      msg_q <= MSG_WIDTH'(msg_in_i);
    end
    if (cmd_i.exec) begin
      out_status_q <= status_d;
      out_msg_q    <= mout_d;
      out_pend_q   <= pend_d;
      if (wr_msg) begin
        slot_msg_q[free_idx] <= msg_q;
      end
      if (wr_link) begin
        slot_link_q[wr_link_idx] <= free_idx;
      end
      if (wr_head) begin
        head_q[t] <= wr_head_val;
      end
      if (wr_tail) begin
        tail_q[t] <= free_idx;
      end
    end
  end

  assign sts_o.out_full = out_valid_q;
  assign res_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign msg_out_o      = MSG_OUT_W'(out_msg_q);
  assign pending_o      = out_pend_q;

`ifndef SYNTHESIS
  // an executed request always leaves a result to transfer
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> out_valid_q)
    else $error("result register not loaded after execution");

  // every non-empty mailbox owns at least one slot
  a_slots_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) >= $countones(nonempty_q))
    else $error("more non-empty mailboxes than used slots");

  // an empty report carries no message and no pending flag
  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_EMPTY) |-> (!out_pend_q && out_msg_q == '0))
    else $error("empty result with message or pending set");
`endif

endmodule

// File: src/per_task_mailbox_queue_manager.sv
// Mailbox for up to eight tasks sharing a pool of eight message slots. Each
// request (send, pick up oldest, query pending) is first captured from the
// transfer and then executed, with the lowest-free-slot search and the
// head/tail/link pointer update running against the pool. The result sits in an
// output register, and the next request is taken while it waits there; a
// request stays in execution only while an untaken result blocks that
// register. A send to a full pool is refused with no effect, a pickup from
// an empty mailbox reports empty, and every result carries the pending flag
// of the addressed task after the request.
module per_task_mailbox_queue_manager
  import ptmq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // task_id[2:0], msg_in[34:3], zero pad
  input  logic [REQ_W-1:0]     s_axis_tuser,  // req_type[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // msg_out[31:0], pending[32], zero pad
  output logic [STATUS_W-1:0]  m_axis_tuser   // status[1:0]
);

  ptmq_cmd_t            cmd;
  ptmq_sts_t            sts;
  logic [MSG_OUT_W-1:0] msg_out;
  logic                 pending;

  ptmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .res_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ptmq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (s_axis_tuser),
    .task_id_i   (s_axis_tdata[TID_W-1:0]),
    .msg_in_i    (s_axis_tdata[TID_W+MSG_IN_W-1:TID_W]),
    .res_ready_i (m_axis_tready),
    .res_valid_o (m_axis_tvalid),
    .status_o    (m_axis_tuser),
    .msg_out_o   (msg_out),
    .pending_o   (pending)
  );

  // Pack the result transfer
  assign m_axis_tdata = {{(M_TDATA_W - MSG_OUT_W - 1){1'b0}}, pending, msg_out};

endmodule
